### rtl/core/smrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrs_pkg
// Types and codes shared by the sensor measure/read sequencer.
// ----------------------------------------------------------------------------
package smrs_pkg;

  localparam int unsigned PrescW = 16;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgAW  = 2;
  localparam int unsigned CfgDW  = 16;

  localparam logic [PrescW-1:0] PrescReset = 16'd500;
  localparam logic [CntW-1:0]   MeasReset  = 8'd5;
  localparam logic [CntW-1:0]   TmoReset   = 8'd10;

  typedef enum logic [CfgAW-1:0] {
    CFG_PRESCALE = 2'd0,
    CFG_MEAS     = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_IDLE  = 2'd0,
    EV_START = 2'd1,
    EV_READ  = 2'd2,
    EV_ACK   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    NT_FAULT   = 2'd0,
    NT_READY   = 2'd1,
    NT_OK      = 2'd2,
    NT_NOT_OK  = 2'd3
  } notice_e;

  localparam logic [2:0] StateIdleCode  = 3'd0;
  localparam logic [2:0] StateFaultCode = 3'd5;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_code;
    logic       bus_done;
    logic       bus_fail;
    logic       start_accepted;
    logic       check_passed;
  } in_t;

  typedef struct packed {
    logic       machine_ran;
    logic       notice_valid;
    logic [1:0] notice_code;
    logic       start_measure;
    logic       start_read;
    logic       bus_reset;
    logic [2:0] state_code;
  } res_t;

  typedef struct packed {
    logic [CfgAW-1:0] addr;
    logic [CfgDW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [PrescW-1:0] prescale_reload;
    logic [CntW-1:0]   measure_wait;
    logic [CntW-1:0]   timeout_limit;
  } cfg_t;

endpackage
`default_nettype wire

### rtl/core/smrs_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrs_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface smrs_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/smrs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smrs_step
// Prescaler, event latch, sticky flags and measure/read state machine;
// advances by one tick on each accepted beat.
// ----------------------------------------------------------------------------
module smrs_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_en_i,
  input  wire smrs_pkg::in_t  beat_i,
  input  wire smrs_pkg::cfg_t cfg_i,
  output smrs_pkg::res_t      res_o
);
  import smrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WAIT_WR = 3'd1,
    ST_CONV    = 3'd2,
    ST_READY   = 3'd3,
    ST_WAIT_RD = 3'd4,
    ST_FAULT   = 3'd5
  } state_e;

  state_e            state_q, state_d;
  logic [PrescW-1:0] presc_q, presc_d;
  logic              pflag_q, pflag_d;
  logic [1:0]        pev_q, pev_d;
  logic              done_q, done_d;
  logic              err_q, err_d;
  logic [CntW-1:0]   tmo_q, tmo_d;
  logic [CntW-1:0]   wait_q, wait_d;
  res_t              res;

  always_comb begin
    res     = '0;
    state_d = state_q;
    tmo_d   = tmo_q;
    wait_d  = wait_q;
    done_d  = done_q | beat_i.bus_done;
    err_d   = err_q | beat_i.bus_fail;
    pflag_d = pflag_q | beat_i.event_valid;
    pev_d   = beat_i.event_valid ? beat_i.event_code : pev_q;

    if (presc_q != '0) begin
      presc_d = presc_q - 1'b1;
    end else begin
      presc_d         = cfg_i.prescale_reload;
      res.machine_ran = 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (pflag_d && pev_d == EV_START) begin
            pflag_d           = 1'b0;
            done_d            = 1'b0;
            err_d             = 1'b0;
            res.start_measure = 1'b1;
            if (beat_i.start_accepted) begin
              tmo_d   = cfg_i.timeout_limit;
              state_d = ST_WAIT_WR;
            end else begin
              res.notice_valid = 1'b1;
              res.notice_code  = NT_FAULT;
              state_d          = ST_FAULT;
            end
          end
        end
        ST_WAIT_WR: begin
          if (err_d) begin
            res.notice_valid = 1'b1;
            res.notice_code  = NT_FAULT;
            state_d          = ST_FAULT;
          end else if (done_d) begin
            wait_d  = cfg_i.measure_wait;
            state_d = ST_CONV;
          end else begin
            tmo_d = tmo_q - 1'b1;
            if (tmo_d == '0) begin
              res.notice_valid = 1'b1;
              res.notice_code  = NT_FAULT;
              state_d          = ST_FAULT;
            end
          end
        end
        ST_CONV: begin
          wait_d = wait_q - 1'b1;
          if (wait_d == '0) begin
            res.notice_valid = 1'b1;
            res.notice_code  = NT_READY;
            state_d          = ST_READY;
          end
        end
        ST_READY: begin
          if (pflag_d && pev_d == EV_READ) begin
            done_d         = 1'b0;
            err_d          = 1'b0;
            pflag_d        = 1'b0;
            res.start_read = 1'b1;
            if (beat_i.start_accepted) begin
              tmo_d   = cfg_i.timeout_limit;
              state_d = ST_WAIT_RD;
            end else begin
              res.notice_valid = 1'b1;
              res.notice_code  = NT_NOT_OK;
              state_d          = ST_FAULT;
            end
          end
        end
        ST_WAIT_RD: begin
          if (err_d) begin
            res.notice_valid = 1'b1;
            res.notice_code  = NT_FAULT;
            state_d          = ST_FAULT;
          end else if (done_d) begin
            res.notice_valid = 1'b1;
            if (beat_i.check_passed) begin
              res.notice_code = NT_OK;
              state_d         = ST_IDLE;
            end else begin
              res.notice_code = NT_NOT_OK;
              state_d         = ST_FAULT;
            end
          end else begin
            tmo_d = tmo_q - 1'b1;
            if (tmo_d == '0) begin
              res.notice_valid = 1'b1;
              res.notice_code  = NT_NOT_OK;
              state_d          = ST_FAULT;
            end
          end
        end
        ST_FAULT: begin
          if (pflag_d && pev_d == EV_ACK) begin
            res.bus_reset = 1'b1;
            done_d        = 1'b0;
            err_d         = 1'b0;
            pflag_d       = 1'b0;
            state_d       = ST_IDLE;
          end
        end
        default: begin
          presc_d = '0;
          state_d = ST_IDLE;
          pev_d   = EV_IDLE;
          pflag_d = 1'b0;
        end
      endcase
    end
    res.state_code = state_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      presc_q <= '0;
      pflag_q <= 1'b0;
      pev_q   <= EV_IDLE;
      done_q  <= 1'b0;
      err_q   <= 1'b0;
      tmo_q   <= '0;
      wait_q  <= '0;
    end else if (step_en_i) begin
      state_q <= state_d;
      presc_q <= presc_d;
      pflag_q <= pflag_d;
      pev_q   <= pev_d;
      done_q  <= done_d;
      err_q   <= err_d;
      tmo_q   <= tmo_d;
      wait_q  <= wait_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sensor_measure_read_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_measure_read_sequencer
// Tick-driven measure/read sequencer for a sensor on a serial bus.
//
//   channel  dir  payload                 accepted when
//   in_i     in   smrs_pkg::in_t          in_i.valid  & in_i.ready
//   res_o    out  smrs_pkg::res_t         res_o.valid & res_o.ready
//   cfg_i    in   smrs_pkg::cfg_wr_t      cfg_i.valid & cfg_i.ready
//
// one tick beat per cycle; the result beat appears in the cycle after acceptance
// the output register frees in the same cycle it is taken, so beats stream
// back to back; in_i.ready drops only while a result is held and not taken
// config writes are always taken; writes to unknown indexes are dropped
// reset loads the config defaults and clears all sequencer state
// ----------------------------------------------------------------------------
module sensor_measure_read_sequencer (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  smrs_stream_if.sink   in_i,
  smrs_stream_if.source res_o,
  smrs_stream_if.sink   cfg_i
);
  import smrs_pkg::*;

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_vld_q;
  logic in_acc;

  assign in_i.ready  = !out_vld_q || res_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

  smrs_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_acc),
    .beat_i    (in_i.data),
    .cfg_i     (cfg_q),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_reload <= PrescReset;
      cfg_q.measure_wait    <= MeasReset;
      cfg_q.timeout_limit   <= TmoReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        CFG_PRESCALE: cfg_q.prescale_reload <= cfg_i.data.wdata;
        CFG_MEAS:     cfg_q.measure_wait    <= cfg_i.data.wdata[CntW-1:0];
        CFG_TIMEOUT:  cfg_q.timeout_limit   <= cfg_i.data.wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  // actions only happen on a machine run
  a_act_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.machine_ran |->
      !res_q.notice_valid && !res_q.start_measure && !res_q.start_read && !res_q.bus_reset)
    else $error("action without machine run");

  // never both bus starts in one run
  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.start_measure && res_q.start_read))
    else $error("measure and read started together");

  // bus reset leaves fault for idle
  a_reset_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.bus_reset |-> res_q.state_code == StateIdleCode)
    else $error("bus reset without return to idle");

  // a fault or check-not-ok notice always lands in the fault state
  a_fault_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.notice_valid &&
      (res_q.notice_code == NT_FAULT || res_q.notice_code == NT_NOT_OK)
      |-> res_q.state_code == StateFaultCode)
    else $error("fault notice outside fault state");

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor measure/read sequencer. Tick beats go in
// through a valid/ready channel and a mirror of the sequencer predicts the
// result beat of each one. Directed runs walk the measure/read paths, faults,
// timeouts and the counter limits; random runs follow the state machine under
// several register settings, with random gaps on both channels and one long
// sink hold that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import smrs_pkg::*;

  localparam int InW        = $bits(in_t);
  localparam int HoldLen    = 60;
  localparam int DrainLimit = 2000;

  typedef enum logic [2:0] {
    SEQ_IDLE    = 3'd0,
    SEQ_WAIT_WR = 3'd1,
    SEQ_CONV    = 3'd2,
    SEQ_READY   = 3'd3,
    SEQ_WAIT_RD = 3'd4,
    SEQ_FAULT   = 3'd5
  } seq_state_e;

  logic clk_i;
  logic rst_ni;

  smrs_stream_if #(.payload_t(in_t))     in_if  ();
  smrs_stream_if #(.payload_t(res_t))    res_if ();
  smrs_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();

  sensor_measure_read_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  logic [PrescW-1:0] sq_reload, sq_presc;
  logic [CntW-1:0]   sq_meas, sq_tmo, sq_tmo_cnt, sq_wait_cnt;
  logic              sq_pend, sq_done, sq_err;
  event_e            sq_pend_ev;
  seq_state_e        sq_st;

  res_t tick_res_q[$];
  bit   src_idle, snk_idle, hold_req;
  int   errors, n_ticks, n_checked, n_notices, n_runs, n_holds;
  logic [7:0] states_seen;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic void seq_reset();
    sq_reload   = PrescReset;
    sq_meas     = MeasReset;
    sq_tmo      = TmoReset;
    sq_presc    = '0;
    sq_st       = SEQ_IDLE;
    sq_pend     = 1'b0;
    sq_pend_ev  = EV_IDLE;
    sq_done     = 1'b0;
    sq_err      = 1'b0;
    sq_tmo_cnt  = '0;
    sq_wait_cnt = '0;
  endfunction

  function automatic res_t seq_tick(in_t t);
    res_t r;
    r = '0;
    if (t.bus_done) sq_done = 1'b1;
    if (t.bus_fail) sq_err = 1'b1;
    if (t.event_valid) begin
      sq_pend    = 1'b1;
      sq_pend_ev = event_e'(t.event_code);
    end
    if (sq_presc != '0) begin
      sq_presc = sq_presc - 1'b1;
    end else begin
      sq_presc = sq_reload;
      r.machine_ran = 1'b1;
      case (sq_st)
        SEQ_IDLE: begin
          if (sq_pend && sq_pend_ev == EV_START) begin
            sq_pend = 1'b0;
            sq_done = 1'b0;
            sq_err  = 1'b0;
            r.start_measure = 1'b1;
            if (t.start_accepted) begin
              sq_tmo_cnt = sq_tmo;
              sq_st = SEQ_WAIT_WR;
            end else begin
              r.notice_valid = 1'b1;
              r.notice_code  = NT_FAULT;
              sq_st = SEQ_FAULT;
            end
          end
        end
        SEQ_WAIT_WR: begin
          if (sq_err) begin
            r.notice_valid = 1'b1;
            r.notice_code  = NT_FAULT;
            sq_st = SEQ_FAULT;
          end else if (sq_done) begin
            sq_wait_cnt = sq_meas;
            sq_st = SEQ_CONV;
          end else begin
            sq_tmo_cnt = sq_tmo_cnt - 1'b1;
            if (sq_tmo_cnt == '0) begin
              r.notice_valid = 1'b1;
              r.notice_code  = NT_FAULT;
              sq_st = SEQ_FAULT;
            end
          end
        end
        SEQ_CONV: begin
          sq_wait_cnt = sq_wait_cnt - 1'b1;
          if (sq_wait_cnt == '0) begin
            r.notice_valid = 1'b1;
            r.notice_code  = NT_READY;
            sq_st = SEQ_READY;
          end
        end
        SEQ_READY: begin
          if (sq_pend && sq_pend_ev == EV_READ) begin
            sq_done = 1'b0;
            sq_err  = 1'b0;
            r.start_read = 1'b1;
            if (t.start_accepted) begin
              sq_tmo_cnt = sq_tmo;
              sq_st = SEQ_WAIT_RD;
            end else begin
              r.notice_valid = 1'b1;
              r.notice_code  = NT_NOT_OK;
              sq_st = SEQ_FAULT;
            end
            sq_pend = 1'b0;
          end
        end
        SEQ_WAIT_RD: begin
          if (sq_err) begin
            r.notice_valid = 1'b1;
            r.notice_code  = NT_FAULT;
            sq_st = SEQ_FAULT;
          end else if (sq_done) begin
            r.notice_valid = 1'b1;
            if (t.check_passed) begin
              r.notice_code = NT_OK;
              sq_st = SEQ_IDLE;
            end else begin
              r.notice_code = NT_NOT_OK;
              sq_st = SEQ_FAULT;
            end
          end else begin
            sq_tmo_cnt = sq_tmo_cnt - 1'b1;
            if (sq_tmo_cnt == '0) begin
              r.notice_valid = 1'b1;
              r.notice_code  = NT_NOT_OK;
              sq_st = SEQ_FAULT;
            end
          end
        end
        SEQ_FAULT: begin
          if (sq_pend && sq_pend_ev == EV_ACK) begin
            r.bus_reset = 1'b1;
            sq_done = 1'b0;
            sq_err  = 1'b0;
            sq_pend = 1'b0;
            sq_st = SEQ_IDLE;
          end
        end
        default: begin
          sq_presc   = '0;
          sq_st      = SEQ_IDLE;
          sq_pend_ev = EV_IDLE;
          sq_pend    = 1'b0;
        end
      endcase
    end
    r.state_code = sq_st;
    return r;
  endfunction

  // mostly well-formed traffic for the current state, some pure noise
  function automatic in_t pick_tick();
    in_t t;
    int  r;
    t = in_t'(InW'($urandom));
    r = $urandom_range(0, 99);
    if (r < 15) return t;
    t.event_valid    = 1'b0;
    t.bus_done       = 1'b0;
    t.bus_fail       = 1'b0;
    t.start_accepted = ($urandom_range(0, 7) != 0);
    t.check_passed   = ($urandom_range(0, 3) != 0);
    case (sq_st)
      SEQ_IDLE: begin
        if (r < 60) begin
          t.event_valid = 1'b1;
          t.event_code  = EV_START;
        end
      end
      SEQ_WAIT_WR, SEQ_WAIT_RD: begin
        t.bus_done = (r >= 75);
        t.bus_fail = (r >= 15 && r < 20);
      end
      SEQ_READY: begin
        if (r < 60) begin
          t.event_valid = 1'b1;
          t.event_code  = EV_READ;
        end
      end
      SEQ_FAULT: begin
        if (r < 50) begin
          t.event_valid = 1'b1;
          t.event_code  = EV_ACK;
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      t.event_valid = 1'b1;
      t.event_code  = 2'($urandom);
    end
    return t;
  endfunction

  task automatic send_tick(in_t t);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tick_res_q.push_back(seq_tick(t));
    n_ticks++;
  endtask

  task automatic tick(bit ev, event_e code, bit dn, bit fl, bit acc, bit ps);
    in_t t;
    t.event_valid    = ev;
    t.event_code     = code;
    t.bus_done       = dn;
    t.bus_fail       = fl;
    t.start_accepted = acc;
    t.check_passed   = ps;
    send_tick(t);
  endtask

  task automatic quiet(int n);
    repeat (n) tick(1'b0, EV_IDLE, 1'b0, 1'b0, 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tick_res_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (tick_res_q.size() != 0) begin
      errors++;
      $display("%0t: %0d result beats never arrived", $time, tick_res_q.size());
      tick_res_q.delete();
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDW-1:0] val);
    cfg_wr_t w;
    w.addr  = idx;
    w.wdata = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_PRESCALE: sq_reload = val;
      CFG_MEAS:     sq_meas   = val[CntW-1:0];
      CFG_TIMEOUT:  sq_tmo    = val[CntW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(logic [PrescW-1:0] presc, logic [CntW-1:0] meas,
                            logic [CntW-1:0] tmo);
    drain();
    cfg_write(CFG_PRESCALE, presc);
    cfg_write(CFG_MEAS, {8'd0, meas});
    cfg_write(CFG_TIMEOUT, {8'd0, tmo});
  endtask

  // steer the machine back to idle, assumes the machine runs every tick
  task automatic settle();
    while (sq_st != SEQ_IDLE) begin
      if (sq_st == SEQ_READY) tick(1'b1, EV_READ, 1'b0, 1'b0, 1'b0, 1'b0);
      else if (sq_st == SEQ_FAULT) tick(1'b1, EV_ACK, 1'b0, 1'b0, 1'b0, 1'b0);
      else tick(1'b0, EV_IDLE, 1'b0, 1'b1, 1'b0, 1'b0);
    end
  endtask

  // stops with the prescaler at zero so the next beat runs the machine
  task automatic test_reset_defaults();
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    repeat (PrescReset) send_tick(pick_tick());
  endtask

  task automatic test_directed();
    set_config(16'd0, 8'd1, 8'd255);
    settle();
    tick(1'b1, EV_IDLE,  1'b0, 1'b0, 1'b1, 1'b1);
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b0, 1'b0, 1'b0, 1'b1);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b0, EV_IDLE,  1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b1, EV_READ,  1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b0, 1'b1);
    // start refused by the bus
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b0, 1'b1);
    tick(1'b1, EV_ACK,   1'b0, 1'b0, 1'b1, 1'b1);
    // done pulse in the start tick is lost
    tick(1'b1, EV_START, 1'b1, 1'b0, 1'b1, 1'b0);
    // error wins over done
    tick(1'b0, EV_IDLE,  1'b1, 1'b1, 1'b0, 1'b0);
    // read waits unused in fault, then the newer ack replaces it
    tick(1'b1, EV_READ,  1'b0, 1'b0, 1'b1, 1'b1);
    tick(1'b1, EV_ACK,   1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b1);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b1, 1'b1);
    tick(1'b0, EV_IDLE,  1'b0, 1'b0, 1'b1, 1'b1);
    tick(1'b1, EV_READ,  1'b0, 1'b0, 1'b0, 1'b1);
    tick(1'b1, EV_ACK,   1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b0, 1'b0);
    tick(1'b1, EV_READ,  1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b1, 1'b0);
    tick(1'b1, EV_ACK,   1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_limits();
    set_config(16'd0, 8'd0, 8'd0);
    settle();
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    quiet(256);
    tick(1'b1, EV_ACK,   1'b0, 1'b0, 1'b0, 1'b0);
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b0, 1'b0);
    quiet(256);
    tick(1'b1, EV_READ,  1'b0, 1'b0, 1'b1, 1'b0);
    tick(1'b0, EV_IDLE,  1'b1, 1'b0, 1'b0, 1'b1);
    set_config(16'd0, 8'd1, 8'd1);
    tick(1'b1, EV_START, 1'b0, 1'b0, 1'b1, 1'b0);
    quiet(1);
    tick(1'b1, EV_ACK,   1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_config(16'd1, 8'd2, 8'd4);
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (80) send_tick(pick_tick());
  endtask

  task automatic random_phase(logic [PrescW-1:0] presc, logic [CntW-1:0] meas,
                              logic [CntW-1:0] tmo, int n);
    set_config(presc, meas, tmo);
    for (int i = 0; i < n; i++) begin
      if (i % 10 == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      send_tick(pick_tick());
    end
  endtask

  task automatic test_random();
    random_phase(16'd0, 8'd1, 8'd1, 40);
    random_phase(16'd0, 8'd255, 8'd255, 40);
    random_phase(16'd1, 8'd3, 8'd4, 40);
    random_phase(16'd3, 8'd2, 8'd1, 40);
    random_phase(16'($urandom_range(0, 5)), 8'($urandom_range(1, 20)),
                 8'($urandom_range(1, 20)), 40);
    random_phase(16'd2, 8'd8, 8'd16, 40);
  endtask

  task automatic test_long_prescale();
    set_config(16'hFFFF, 8'd255, 8'd255);
    repeat (12) send_tick(pick_tick());
  endtask

  task automatic bad_field(string name, logic [2:0] want, logic [2:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin : res_check
    res_t got;
    res_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = res_if.data;
      n_checked++;
      if (got.notice_valid === 1'b1) n_notices++;
      if (got.machine_ran === 1'b1) n_runs++;
      if (got.state_code <= 3'd7) states_seen[got.state_code] = 1'b1;
      if (tick_res_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none awaited, got %p", $time, got);
      end else begin
        want = tick_res_q.pop_front();
        if (got.machine_ran !== want.machine_ran)
          bad_field("machine_ran", want.machine_ran, got.machine_ran);
        if (got.notice_valid !== want.notice_valid)
          bad_field("notice_valid", want.notice_valid, got.notice_valid);
        if (got.notice_code !== want.notice_code)
          bad_field("notice_code", want.notice_code, got.notice_code);
        if (got.start_measure !== want.start_measure)
          bad_field("start_measure", want.start_measure, got.start_measure);
        if (got.start_read !== want.start_read)
          bad_field("start_read", want.start_read, got.start_read);
        if (got.bus_reset !== want.bus_reset)
          bad_field("bus_reset", want.bus_reset, got.bus_reset);
        if (got.state_code !== want.state_code)
          bad_field("state_code", want.state_code, got.state_code);
      end
    end
  end

  // sink side, per beat stall plus the one long hold
  initial begin : res_sink
    int stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        stall    = HoldLen;
        hold_req = 1'b0;
        n_holds++;
      end else begin
        stall = snk_idle ? $urandom_range(0, 11) : 0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    src_idle     = 1'b1;
    snk_idle     = 1'b1;
    hold_req     = 1'b0;
    errors       = 0;
    n_ticks      = 0;
    n_checked    = 0;
    n_notices    = 0;
    n_runs       = 0;
    n_holds      = 0;
    states_seen  = '0;
    seq_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    test_long_prescale();
    drain();

    $display("tb: %0d tick beats, %0d result beats checked, %0d machine runs, %0d notices",
             n_ticks, n_checked, n_runs, n_notices);
    $display("tb: states reached %b, %0d long sink holds, %0d mismatches",
             states_seen, n_holds, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
